@@ src/pnguf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnguf_pkg
// Shared types and codes of the scanline unfilter: filter codes, register
// indexes and the request token that rides alongside the line buffer read.
// ----------------------------------------------------------------------------
package pnguf_pkg;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } pnguf_filt_t;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_BPP        = 2'd0;
    localparam logic [1:0] REG_ROW_BYTES  = 2'd1;
    localparam logic [1:0] REG_IMAGE_ROWS = 2'd2;

    typedef struct packed {
        logic        is_filter;
        pnguf_filt_t filt;
        logic        bad;
        logic        up_ok;
        logic        wr_ok;
        logic        row_end;
        logic        image_end;
        logic [7:0]  data;
    } pnguf_tok_t;

endpackage
`default_nettype wire

@@ src/pnguf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnguf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pnguf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire                      re,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ src/pnguf_predict.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnguf_predict
// Filter predictor: forms None, Sub, Up, Average or Paeth prediction and
// adds it to the filtered byte, mod 256.
// ----------------------------------------------------------------------------
module pnguf_predict (
    input  wire pnguf_pkg::pnguf_filt_t filt,
    input  wire [7:0]                   x,
    input  wire [7:0]                   left,
    input  wire [7:0]                   up,
    input  wire [7:0]                   upleft,
    output logic [7:0]                  pix
);

    logic signed [10:0] pa_s, pb_s, pc_s;
    logic        [9:0]  pa, pb, pc;
    logic        [8:0]  avg_sum;
    logic        [7:0]  paeth;
    logic        [7:0]  pred;

    always_comb begin
        // p = a + b - c: distances reduce to |b-c|, |a-c|, |a+b-2c|
        pa_s = $signed({3'b000, up}) - $signed({3'b000, upleft});
        pb_s = $signed({3'b000, left}) - $signed({3'b000, upleft});
        pc_s = $signed({3'b000, left}) + $signed({3'b000, up})
             - $signed({2'b00, upleft, 1'b0});
        pa = pa_s[10] ? 10'(-pa_s) : pa_s[9:0];
        pb = pb_s[10] ? 10'(-pb_s) : pb_s[9:0];
        pc = pc_s[10] ? 10'(-pc_s) : pc_s[9:0];

        priority if (pa <= pb && pa <= pc) begin
            paeth = left;
        end else if (pb <= pc) begin
            paeth = up;
        end else begin
            paeth = upleft;
        end

        avg_sum = {1'b0, left} + {1'b0, up};

        unique case (filt)
            pnguf_pkg::FILT_SUB:   pred = left;
            pnguf_pkg::FILT_UP:    pred = up;
            pnguf_pkg::FILT_AVG:   pred = avg_sum[8:1];
            pnguf_pkg::FILT_PAETH: pred = paeth;
            default:               pred = 8'd0;
        endcase

        pix = x + pred;
    end

endmodule
`default_nettype wire

@@ src/png_scanline_unfilter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A data byte passes the request register, then the output register. The up
// operand comes from a line-buffer RAM with registered read data, issued at
// acceptance; left/up-left sit in registers. Throughput: one byte per cycle
// unless m_tready stalls output, filter bytes included but giving no result.
// Reset (aresetn low, synchronous): control and registers to defaults; the
// line buffer is not cleared and holds garbage until the first row writes it.
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG scanline unfilter: rebuilds raw image bytes from the filtered stream.
// ----------------------------------------------------------------------------
module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES = 8192
) (
    input  wire         aclk,
    input  wire         aresetn,
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // filtered stream in
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] stream_byte
    // raw bytes out
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // [7:0] pixel_byte
    output logic        m_tlast,   // row_end
    output logic [1:0]  m_tuser    // [0] image_end, [1] bad_filter
);

    localparam int          ADDR_W = $clog2(MAX_ROW_BYTES);
    localparam logic [17:0] MAX_W  = 18'(MAX_ROW_BYTES);

    // configuration registers
    logic [2:0]  bpp_reg;
    logic [13:0] row_bytes_reg;
    logic [15:0] image_rows_reg;

    // sequencing state
    logic                   expect_reg, expect_next;
    logic [13:0]            col_reg, col_next;
    logic [15:0]            row_reg, row_next;
    pnguf_pkg::pnguf_filt_t filt_reg, filt_next;
    logic                   err_reg, err_next;

    // request waiting on the line-buffer read
    pnguf_pkg::pnguf_tok_t  tok_reg, tok_next;
    logic [ADDR_W-1:0]      tok_addr_reg;
    logic                   tok_valid_reg, tok_valid_next;

    logic [7:0] left_hist_reg [4];
    logic [7:0] up_hist_reg   [4];

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_pix_reg;
    logic       m_last_reg, m_iend_reg, m_bad_reg;

    logic              cfg_wr, in_acc, tok_go;
    logic [1:0]        hist_idx;
    logic [17:0]       rb_eff, col_w, col_inc;
    logic [16:0]       rows_eff, row_inc;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        ram_rdata, up, pix;
    logic              rend, iend;

    // ---------------------------------------------------------------- config
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        unique case (paddr[3:2])
            pnguf_pkg::REG_BPP:        prdata = {29'd0, bpp_reg};
            pnguf_pkg::REG_ROW_BYTES:  prdata = {18'd0, row_bytes_reg};
            pnguf_pkg::REG_IMAGE_ROWS: prdata = {16'd0, image_rows_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // clamp register values into their working ranges
    always_comb begin
        if (bpp_reg == 3'd0) begin
            hist_idx = 2'd0;
        end else if (bpp_reg > 3'd4) begin
            hist_idx = 2'd3;
        end else begin
            hist_idx = 2'(bpp_reg - 3'd1);
        end

        if (row_bytes_reg == 14'd0) begin
            rb_eff = 18'd1;
        end else if ({4'd0, row_bytes_reg} > MAX_W) begin
            rb_eff = MAX_W;
        end else begin
            rb_eff = {4'd0, row_bytes_reg};
        end

        rows_eff = (image_rows_reg == 16'd0) ? 17'd1 : {1'b0, image_rows_reg};
    end

    // ------------------------------------------------------------ handshake
    assign tok_go   = tok_valid_reg & (tok_reg.is_filter | ~m_valid_reg | m_tready);
    assign s_tready = ~tok_valid_reg | tok_go;
    assign in_acc   = s_tvalid & s_tready;

    // ------------------------------------------------------------ sequencer
    always_comb begin
        col_w   = {4'd0, col_reg};
        col_inc = col_w + 18'd1;
        row_inc = {1'b0, row_reg} + 17'd1;
        rd_addr = col_w[ADDR_W-1:0];
        rend    = col_inc >= rb_eff;
        iend    = rend && (row_inc >= rows_eff);

        expect_next    = expect_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        filt_next      = filt_reg;
        err_next       = err_reg;

        tok_next.is_filter = expect_reg;
        tok_next.filt      = filt_reg;
        tok_next.bad       = err_reg;
        tok_next.up_ok     = (row_reg != 16'd0) && (col_w < MAX_W);
        tok_next.wr_ok     = col_w < MAX_W;
        tok_next.row_end   = rend;
        tok_next.image_end = iend;
        tok_next.data      = s_tdata;

        if (in_acc) begin
            if (expect_reg) begin
                err_next    = s_tdata > {5'd0, pnguf_pkg::FILT_PAETH};
                filt_next   = err_next ? pnguf_pkg::FILT_NONE
                                       : pnguf_pkg::pnguf_filt_t'(s_tdata[2:0]);
                col_next    = 14'd0;
                expect_next = 1'b0;
            end else if (rend) begin
                expect_next = 1'b1;
                col_next    = 14'd0;
                row_next    = iend ? 16'd0 : row_inc[15:0];
            end else begin
                col_next = col_inc[13:0];
            end
        end

        if (in_acc) begin
            tok_valid_next = 1'b1;
        end else if (tok_go) begin
            tok_valid_next = 1'b0;
        end else begin
            tok_valid_next = tok_valid_reg;
        end

        if (tok_go && !tok_reg.is_filter) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg        <= 3'd3;
            row_bytes_reg  <= 14'd3;
            image_rows_reg <= 16'd1;
            expect_reg     <= 1'b1;
            col_reg        <= 14'd0;
            row_reg        <= 16'd0;
            filt_reg       <= pnguf_pkg::FILT_NONE;
            err_reg        <= 1'b0;
            tok_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    pnguf_pkg::REG_BPP:        bpp_reg        <= pwdata[2:0];
                    pnguf_pkg::REG_ROW_BYTES:  row_bytes_reg  <= pwdata[13:0];
                    pnguf_pkg::REG_IMAGE_ROWS: image_rows_reg <= pwdata[15:0];
                    default: ;
                endcase
            end
            expect_reg    <= expect_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            filt_reg      <= filt_next;
            err_reg       <= err_next;
            tok_valid_reg <= tok_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // ---------------------------------------------------------- line buffer
    pnguf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (tok_go & ~tok_reg.is_filter & tok_reg.wr_ok),
        .waddr (tok_addr_reg),
        .wdata (pix),
        .re    (in_acc),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------- rebuild
    assign up = tok_reg.up_ok ? ram_rdata : 8'd0;

    pnguf_predict u_predict (
        .filt   (tok_reg.filt),
        .x      (tok_reg.data),
        .left   (left_hist_reg[hist_idx]),
        .up     (up),
        .upleft (up_hist_reg[hist_idx]),
        .pix    (pix)
    );

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            tok_reg      <= tok_next;
            tok_addr_reg <= rd_addr;
        end
        if (tok_go) begin
            if (tok_reg.is_filter) begin
                // drop history at row start
                for (int i = 0; i < 4; i++) begin
                    left_hist_reg[i] <= 8'd0;
                    up_hist_reg[i]   <= 8'd0;
                end
            end else begin
                for (int i = 3; i > 0; i--) begin
                    left_hist_reg[i] <= left_hist_reg[i-1];
                    up_hist_reg[i]   <= up_hist_reg[i-1];
                end
                left_hist_reg[0] <= pix;
                up_hist_reg[0]   <= up;
                m_pix_reg        <= pix;
                m_last_reg       <= tok_reg.row_end;
                m_iend_reg       <= tok_reg.image_end;
                m_bad_reg        <= tok_reg.bad;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pix_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_bad_reg, m_iend_reg};

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: PNG scanline unfilter testbench
// Streams filtered scanlines into the unfilter and checks every rebuilt byte,
// with its row, image and bad-filter marks, against a byte-exact prediction
// kept in a small tracker class. Register writes go over APB while the block
// is idle. Both stream sides idle at random, and the output stalls for a
// long stretch at least once.
// ----------------------------------------------------------------------------
module tb;

    localparam int LINE_BYTES = 8192;

    // Mirrors the unfilter: registers, line buffer, pixel histories and the
    // rebuilt bytes still to come out.
    class raw_byte_tracker;
        typedef struct {
            bit [7:0] pixel;
            bit       row_end;
            bit       image_end;
            bit       bad;
        } raw_byte_t;

        bit [2:0]    bpp_reg;
        bit [13:0]   row_bytes_reg;
        bit [15:0]   rows_reg;
        bit [7:0]    prior_line [LINE_BYTES];
        bit [7:0]    left_hist [4];
        bit [7:0]    upleft_hist [4];
        pnguf_pkg::pnguf_filt_t filt;
        bit          row_bad;
        bit          at_filter;
        int unsigned col;
        int unsigned row;
        raw_byte_t   raw_due [$];
        int          mismatches;
        int          checked;
        int          images;
        int          bad_rows;

        function new();
            bpp_reg       = 3'd3;
            row_bytes_reg = 14'd3;
            rows_reg      = 16'd1;
            filt          = pnguf_pkg::FILT_NONE;
            at_filter     = 1'b1;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                pnguf_pkg::REG_BPP:        bpp_reg = val[2:0];
                pnguf_pkg::REG_ROW_BYTES:  row_bytes_reg = val[13:0];
                pnguf_pkg::REG_IMAGE_ROWS: rows_reg = val[15:0];
                default: ;
            endcase
        endfunction

        function int row_len();
            if (row_bytes_reg == 0) return 1;
            if (row_bytes_reg > LINE_BYTES) return LINE_BYTES;
            return row_bytes_reg;
        endfunction

        function int rows_eff();
            return (rows_reg == 0) ? 1 : rows_reg;
        endfunction

        function int pending();
            return raw_due.size();
        endfunction

        function int paeth_pick(int a, int b, int c);
            int pa, pb, pc;
            pa = (b > c) ? b - c : c - b;
            pb = (a > c) ? a - c : c - a;
            pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
            if (pa <= pb && pa <= pc) return a;
            if (pb <= pc) return b;
            return c;
        endfunction

        function void note_filtered_byte(bit [7:0] x);
            int        a, b, c, d, pred, k;
            raw_byte_t r;
            if (at_filter) begin
                // unknown types fall back to None and flag the row
                row_bad = (x > 8'd4);
                filt = row_bad ? pnguf_pkg::FILT_NONE : pnguf_pkg::pnguf_filt_t'(x[2:0]);
                if (row_bad) bad_rows++;
                col = 0;
                for (k = 0; k < 4; k++) begin
                    left_hist[k] = 8'h00;
                    upleft_hist[k] = 8'h00;
                end
                at_filter = 1'b0;
                return;
            end
            d = ((bpp_reg == 0) ? 1 : ((bpp_reg > 4) ? 4 : int'(bpp_reg))) - 1;
            a = left_hist[d];
            c = upleft_hist[d];
            b = (row > 0) ? int'(prior_line[col]) : 0;
            case (filt)
                pnguf_pkg::FILT_SUB:   pred = a;
                pnguf_pkg::FILT_UP:    pred = b;
                pnguf_pkg::FILT_AVG:   pred = (a + b) / 2;
                pnguf_pkg::FILT_PAETH: pred = paeth_pick(a, b, c);
                default:               pred = 0;
            endcase
            r.pixel = 8'(int'(x) + pred);
            prior_line[col] = r.pixel;
            for (k = 3; k > 0; k--) begin
                left_hist[k] = left_hist[k - 1];
                upleft_hist[k] = upleft_hist[k - 1];
            end
            left_hist[0] = r.pixel;
            upleft_hist[0] = 8'(b);
            r.row_end = (col + 1 >= row_len());
            r.image_end = 1'b0;
            r.bad = row_bad;
            if (r.row_end) begin
                at_filter = 1'b1;
                col = 0;
                if (row + 1 >= rows_eff()) begin
                    r.image_end = 1'b1;
                    row = 0;
                end else begin
                    row++;
                end
            end else begin
                col++;
            end
            raw_due.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_raw_byte(bit [7:0] pix, bit last, bit [1:0] user);
            raw_byte_t e;
            checked++;
            if (raw_due.size() == 0) begin
                report($sformatf("raw byte %02h with nothing outstanding", pix));
                return;
            end
            e = raw_due.pop_front();
            if (pix != e.pixel)
                report($sformatf("pixel %02h, predicted %02h", pix, e.pixel));
            if (last != e.row_end)
                report($sformatf("row_end %0b, predicted %0b", last, e.row_end));
            if (user[0] != e.image_end)
                report($sformatf("image_end %0b, predicted %0b", user[0], e.image_end));
            if (user[1] != e.bad)
                report($sformatf("bad_filter %0b, predicted %0b", user[1], e.bad));
            if (e.image_end) images++;
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;   // [7:0] pixel_byte
    logic        m_tlast;   // row_end
    logic [1:0]  m_tuser;   // [0] image_end, [1] bad_filter

    raw_byte_tracker sb = new();
    bit steady;
    int hold_off;
    int bytes_sent;
    int random_sent;
    bit random_phase;

    png_scanline_unfilter #(.MAX_ROW_BYTES(LINE_BYTES)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    initial begin
        #10_000_000;
        $display("timed out with %0d raw bytes outstanding", sb.pending());
        $display("end of test: mismatches");
        $finish;
    end

    task write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task send_byte(bit [7:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        sb.note_filtered_byte(b);
        bytes_sent++;
        if (random_phase) random_sent++;
    endtask

    // drop valid and wait until every rebuilt byte is out
    task settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task send_row(bit [7:0] ftype, int n, int style);
        bit [7:0] base, v;
        int       i;
        send_byte(ftype);
        base = $urandom_range(0, 255);
        for (i = 0; i < n; i++) begin
            case (style)
                0: v = $urandom_range(0, 255);
                1: v = base + 8'($urandom_range(0, 3));
                default: begin
                    case ($urandom_range(0, 3))
                        0: v = 8'h00;
                        1: v = 8'hFF;
                        2: v = 8'h80;
                        default: v = 8'h7F;
                    endcase
                end
            endcase
            send_byte(v);
        end
    endtask

    function bit [7:0] pick_filter();
        int r;
        r = $urandom_range(0, 15);
        if (r < 12) return 8'(r % 5);
        if (r < 14) return 8'($urandom_range(5, 255));
        return 8'($urandom_range(0, 255));
    endfunction

    task send_image();
        int r;
        for (r = 0; r < sb.rows_eff(); r++)
            send_row(pick_filter(), sb.row_len(), $urandom_range(0, 2));
    endtask

    initial begin : drain_side
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 3);
            if (hold_off > 0) begin
                gap = hold_off;
                hold_off = 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_raw_byte(m_tdata, m_tlast, m_tuser);
        end
    end

    initial begin : stimulus
        bit first;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: three bytes, one row
        send_row(pnguf_pkg::FILT_NONE, 3, 2);
        settle();

        // every filter type plus unknown ones, one byte per pixel
        write_reg(pnguf_pkg::REG_BPP, 32'd1);
        write_reg(pnguf_pkg::REG_ROW_BYTES, 32'd3);
        write_reg(pnguf_pkg::REG_IMAGE_ROWS, 32'd7);
        send_row(pnguf_pkg::FILT_NONE, 3, 2);
        send_row(pnguf_pkg::FILT_SUB, 3, 2);
        send_row(pnguf_pkg::FILT_UP, 3, 2);
        send_row(pnguf_pkg::FILT_AVG, 3, 2);
        send_row(pnguf_pkg::FILT_PAETH, 3, 2);
        send_row(8'd5, 3, 2);
        send_row(8'd255, 3, 2);
        settle();

        // zero registers clamp to one
        write_reg(pnguf_pkg::REG_BPP, 32'd0);
        write_reg(pnguf_pkg::REG_ROW_BYTES, 32'd0);
        write_reg(pnguf_pkg::REG_IMAGE_ROWS, 32'd0);
        send_row(pnguf_pkg::FILT_SUB, 1, 2);
        settle();

        // shrink the row length mid-row: the next byte closes the row
        write_reg(pnguf_pkg::REG_BPP, 32'd7);
        write_reg(pnguf_pkg::REG_ROW_BYTES, 32'd16383);
        write_reg(pnguf_pkg::REG_IMAGE_ROWS, 32'd2);
        send_row(pnguf_pkg::FILT_PAETH, 10, 0);
        settle();
        write_reg(pnguf_pkg::REG_ROW_BYTES, 32'd4);
        send_byte(8'h5A);
        send_row(pnguf_pkg::FILT_PAETH, 4, 0);
        settle();

        // shrink the row count mid-image: the current row closes the image
        write_reg(pnguf_pkg::REG_BPP, 32'd2);
        write_reg(pnguf_pkg::REG_ROW_BYTES, 32'd2);
        write_reg(pnguf_pkg::REG_IMAGE_ROWS, 32'd65535);
        repeat (3) send_row(pnguf_pkg::FILT_AVG, 2, 0);
        settle();
        write_reg(pnguf_pkg::REG_IMAGE_ROWS, 32'd2);
        send_row(pnguf_pkg::FILT_UP, 2, 0);
        settle();

        // long row, twice, so the second reads back the whole line
        write_reg(pnguf_pkg::REG_BPP, 32'd4);
        write_reg(pnguf_pkg::REG_ROW_BYTES, 32'd256);
        send_row(pnguf_pkg::FILT_SUB, 256, 0);
        send_row(pnguf_pkg::FILT_PAETH, 256, 0);
        settle();

        random_phase = 1'b1;
        first = 1'b1;
        while (random_sent < 1200) begin
            if (first) begin
                write_reg(pnguf_pkg::REG_BPP, 32'd3);
                write_reg(pnguf_pkg::REG_ROW_BYTES, 32'd32);
                write_reg(pnguf_pkg::REG_IMAGE_ROWS, 32'd4);
                // stall the output while input keeps coming
                steady = 1'b1;
                hold_off = 150;
            end else begin
                if ($urandom_range(0, 2) != 0) begin
                    settle();
                    write_reg(pnguf_pkg::REG_BPP, $urandom_range(0, 7));
                    case ($urandom_range(0, 19))
                        0: write_reg(pnguf_pkg::REG_ROW_BYTES, 32'd0);
                        1: write_reg(pnguf_pkg::REG_ROW_BYTES, $urandom_range(100, 400));
                        default: write_reg(pnguf_pkg::REG_ROW_BYTES, $urandom_range(1, 24));
                    endcase
                    write_reg(pnguf_pkg::REG_IMAGE_ROWS, $urandom_range(0, 6));
                end
                steady = ($urandom_range(0, 3) == 0);
            end
            send_image();
            first = 1'b0;
        end
        steady = 1'b0;
        settle();

        $display("%0d filtered bytes in, %0d raw bytes checked over %0d images",
                 bytes_sent, sb.checked, sb.images);
        $display("%0d rows with unknown filter type; rows up to 400 bytes, clamped registers",
                 sb.bad_rows);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
src/pnguf_pkg.sv
src/pnguf_ram.sv
src/pnguf_predict.sv
src/png_scanline_unfilter.sv
verif/tb.sv
